FILE: rtl/sha_pkg.sv
package sha_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	// byte and word moves of the block window
	typedef struct packed {
		logic       byte_en;
		logic [7:0] byte_val;
		logic       word_en;
	} sched_ctl_t;

	// compression core commands
	typedef struct packed {
		logic load;
		logic round;
		logic fold;
		logic iv;
	} core_ctl_t;

	localparam int unsigned NUM_ROUNDS = 64;
	localparam int unsigned NUM_WORDS  = 8;
	localparam int unsigned RND_W      = $clog2(NUM_ROUNDS);
	localparam int unsigned IDX_W      = $clog2(NUM_WORDS);

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] IV_TAB [NUM_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] K_TAB [NUM_ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		bsig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		bsig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		ssig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		ssig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

FILE: rtl/sha_sched.sv
module sha_sched (
	input  logic               clk,
	input  sha_pkg::sched_ctl_t ctl,
	output logic [31:0]        w_cur
);

	// 64-byte window: bytes shift in at the low end, oldest word sits on top
	logic [511:0] window_q;
	logic [31:0]  w1;
	logic [31:0]  w9;
	logic [31:0]  w14;
	logic [31:0]  w_new;

	assign w_cur = window_q[511:480];
	assign w1    = window_q[479:448];
	assign w9    = window_q[223:192];
	assign w14   = window_q[63:32];
	assign w_new = sha_pkg::ssig1(w14) + w9 + sha_pkg::ssig0(w1) + w_cur;

	always_ff @(posedge clk) begin
		if (ctl.word_en) begin
			window_q <= {window_q[479:0], w_new};
		end else if (ctl.byte_en) begin
			window_q <= {window_q[503:0], ctl.byte_val};
		end
	end

endmodule

FILE: rtl/sha_core.sv
module sha_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sha_pkg::core_ctl_t          ctl,
	input  logic [sha_pkg::RND_W-1:0]   rnd,
	input  logic [31:0]                 w_cur,
	input  logic [sha_pkg::IDX_W-1:0]   rd_idx,
	output logic [31:0]                 rd_word
);

	logic [31:0] chain_q [sha_pkg::NUM_WORDS];
	logic [31:0] v_q     [sha_pkg::NUM_WORDS];
	logic [31:0] t1;
	logic [31:0] t2;

	assign t1 = v_q[7] + sha_pkg::bsig1(v_q[4])
		+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ sha_pkg::K_TAB[rnd] + w_cur;
	assign t2 = sha_pkg::bsig0(v_q[0])
		+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	assign rd_word = chain_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sha_pkg::NUM_WORDS; i++) begin
				chain_q[i] <= sha_pkg::IV_TAB[i];
			end
		end else if (ctl.iv) begin
			for (int i = 0; i < sha_pkg::NUM_WORDS; i++) begin
				chain_q[i] <= sha_pkg::IV_TAB[i];
			end
		end else if (ctl.fold) begin
			for (int i = 0; i < sha_pkg::NUM_WORDS; i++) begin
				chain_q[i] <= chain_q[i] + v_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			v_q <= chain_q;
		end else if (ctl.round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

endmodule

FILE: rtl/sha256_stream_hash.sv
// channel | valid     | stall     | payload
// msg     | msg_valid | msg_stall | msg (data_byte, byte_present, is_last)
// dig     | dig_valid | dig_stall | dig (digest_word, word_index, last_word)
//
// message bytes are taken while msg_stall is low; the byte that fills a block starts the rounds
// and then the fold, all on the single round unit.
// the end mark adds one pad byte per cycle up to the block end (one or two blocks),
// and each padded block is compressed and folded; then eight digest words go out, one per accepted cycle.
// reset loads the initial hash values and clears the count; the block window is not cleared.
// msg_stall is high whenever a block is being compressed, padded or the digest is out;
// a stalled digest word holds until taken.
module sha256_stream_hash (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                msg_valid,
	output logic                msg_stall,
	input  sha_pkg::in_item_t   msg,
	output logic                dig_valid,
	input  logic                dig_stall,
	output sha_pkg::out_item_t  dig
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_PAD  = 5'b00010,
		S_RND  = 5'b00100,
		S_FIN  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	localparam logic [5:0] POS_LAST  = 6'd63;
	localparam logic [5:0] POS_ROOM  = 6'd55;
	localparam logic [sha_pkg::RND_W-1:0] RND_LAST = sha_pkg::RND_W'(sha_pkg::NUM_ROUNDS - 1);
	localparam logic [sha_pkg::IDX_W-1:0] IDX_LAST = sha_pkg::IDX_W'(sha_pkg::NUM_WORDS - 1);

	state_t                     state_q;
	logic [60:0]                byte_count_q;
	logic [5:0]                 pos_q;
	logic [sha_pkg::RND_W-1:0]  rnd_q;
	logic [sha_pkg::IDX_W-1:0]  out_idx_q;
	logic                       last_q;
	logic                       pad_mode_q;
	logic                       first_q;
	logic                       final_q;

	logic                       msg_acc;
	logic                       dig_acc;
	logic [5:0]                 pos_nx;
	logic [63:0]                len_sh;
	logic [7:0]                 pad_byte;
	logic [31:0]                w_cur;
	logic [31:0]                rd_word;
	sha_pkg::sched_ctl_t        sctl;
	sha_pkg::core_ctl_t         cctl;

	assign msg_stall = (state_q != S_IDLE);
	assign msg_acc   = msg_valid && !msg_stall;
	assign dig_valid = (state_q == S_OUT);
	assign dig_acc   = dig_valid && !dig_stall;
	assign pos_nx    = pos_q + {5'd0, msg.byte_present};

	// length field goes out big-endian: byte 56 carries the top byte
	assign len_sh   = {byte_count_q, 3'b000} >> {~pos_q[2:0], 3'b000};
	assign pad_byte = first_q ? sha_pkg::PAD_BYTE
		: (final_q && (pos_q[5:3] == 3'b111)) ? len_sh[7:0] : 8'd0;

	always_comb begin
		sctl.byte_en  = (msg_acc && msg.byte_present) || (state_q == S_PAD);
		sctl.byte_val = (state_q == S_PAD) ? pad_byte : msg.data_byte;
		sctl.word_en  = (state_q == S_RND);
		cctl.load     = (sctl.byte_en && (pos_q == POS_LAST));
		cctl.round    = (state_q == S_RND);
		cctl.fold     = (state_q == S_FIN);
		cctl.iv       = dig_acc && (out_idx_q == IDX_LAST);
	end

	sha_sched u_sched (
		.clk   (clk),
		.ctl   (sctl),
		.w_cur (w_cur)
	);

	sha_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (cctl),
		.rnd     (rnd_q),
		.w_cur   (w_cur),
		.rd_idx  (out_idx_q),
		.rd_word (rd_word)
	);

	assign dig.digest_word = rd_word;
	assign dig.word_index  = out_idx_q;
	assign dig.last_word   = (out_idx_q == IDX_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			byte_count_q <= '0;
			pos_q        <= '0;
			rnd_q        <= '0;
			out_idx_q    <= '0;
			last_q       <= 1'b0;
			pad_mode_q   <= 1'b0;
			first_q      <= 1'b0;
			final_q      <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (msg_acc) begin
						last_q <= msg.is_last;
						if (msg.byte_present) begin
							byte_count_q <= byte_count_q + 61'd1;
							pos_q        <= pos_nx;
						end
						if (msg.byte_present && (pos_q == POS_LAST)) begin
							pad_mode_q <= 1'b0;
							rnd_q      <= '0;
							state_q    <= S_RND;
						end else if (msg.is_last) begin
							pad_mode_q <= 1'b1;
							first_q    <= 1'b1;
							final_q    <= (pos_nx <= POS_ROOM);
							state_q    <= S_PAD;
						end
					end
				end
				S_PAD: begin
					pos_q   <= pos_q + 6'd1;
					first_q <= 1'b0;
					if (pos_q == POS_LAST) begin
						rnd_q   <= '0;
						state_q <= S_RND;
					end
				end
				S_RND: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == RND_LAST) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!pad_mode_q) begin
						if (last_q) begin
							// end mark came with the byte that filled the block
							pad_mode_q <= 1'b1;
							first_q    <= 1'b1;
							final_q    <= 1'b1;
							state_q    <= S_PAD;
						end else begin
							state_q <= S_IDLE;
						end
					end else if (final_q) begin
						out_idx_q <= '0;
						state_q   <= S_OUT;
					end else begin
						final_q <= 1'b1;
						state_q <= S_PAD;
					end
				end
				S_OUT: begin
					if (dig_acc) begin
						out_idx_q <= out_idx_q + 1'b1;
						if (out_idx_q == IDX_LAST) begin
							byte_count_q <= '0;
							pad_mode_q   <= 1'b0;
							state_q      <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_fill_starts_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(msg_acc && msg.byte_present && (pos_q == POS_LAST)) |=> (state_q == S_RND))
		else $error("full block did not start compression");

	a_idle_pos_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (pos_q == byte_count_q[5:0]))
		else $error("fill position out of step with byte count");

	a_round_counter_steps: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_RND) && (rnd_q != RND_LAST)) |=>
		((state_q == S_RND) && (rnd_q == sha_pkg::RND_W'($past(rnd_q) + 1'b1))))
		else $error("round counter skipped");

	a_digest_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_acc && dig.last_word) |=> ((state_q == S_IDLE) && (byte_count_q == 61'd0)))
		else $error("message state not cleared after digest");

	a_pad_only_in_last_block_len: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_PAD) && first_q) |-> (pad_mode_q && !sctl.word_en))
		else $error("pad byte outside padding");

endmodule
